// ===== hdl/rdmc_pkg.sv =====
// Shared constants, codes and types of the maze carver.
`timescale 1ns / 1ps
package rdmc_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
  localparam int X_W        = 6;
  localparam int Y_W        = 6;
  localparam int CELL_W     = 12;
  localparam int CNT_W      = CELL_W + 1;
  localparam int SIZE_W     = 7;
  localparam int EPOCH_W    = 4;
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 4;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [1:0] REG_START_X     = 2'd2;
  localparam logic [1:0] REG_START_Y     = 2'd3;

  localparam logic OP_START = 1'b0;
  localparam logic OP_DRAW  = 1'b1;

  typedef enum logic [1:0] {
    DIR_NORTH = 2'd0,
    DIR_EAST  = 2'd1,
    DIR_SOUTH = 2'd2,
    DIR_WEST  = 2'd3
  } dir_e;

  typedef enum logic [2:0] {
    EV_REJECTED    = 3'd0,
    EV_CARVED      = 3'd1,
    EV_BACKTRACKED = 3'd2,
    EV_FINISHED    = 3'd3,
    EV_STARTED     = 3'd4
  } event_e;

endpackage

// ===== hdl/rdmc_if.sv =====
// Item and result channel interfaces of the maze carver.
`timescale 1ns / 1ps
interface rdmc_item_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [1:0] random_dir;

  modport source (output valid, output op, output random_dir, input ready);
  modport sink (input valid, input op, input random_dir, output ready);
endinterface

interface rdmc_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [5:0] cell_x;
  logic [5:0] cell_y;
  logic [1:0] carve_dir;
  logic       done_res;

  modport source (output valid, output event_res, output cell_x, output cell_y,
                  output carve_dir, output done_res, input ready);
  modport sink (input valid, input event_res, input cell_x, input cell_y,
                input carve_dir, input done_res, output ready);
endinterface

// ===== hdl/rdmc_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module rdmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/random_dfs_maze_carver_unit.sv =====
// Top level of the randomised depth-first maze carver.
//
//  channel   | dir | handshake     | payload
//  item_i    | in  | valid/ready   | op, random_dir
//  result_o  | out | valid/ready   | event_res, cell_x, cell_y, carve_dir, done_res
//  APB       | in  | psel/penable  | grid_width, grid_height, start_x, start_y
//
// An item is read from the visited and stack memories in the read stage, then
// decided, written back and loaded into the result register in the decide stage.
// After reset the visited memory is swept with item_i.ready low; the same sweep
// runs whenever the visit epoch wraps, on the sixteenth start after reset and on
// every fifteenth start after that. A stalled result holds in the output register
// and the next item is still taken; a second one waits until the result leaves.
`timescale 1ns / 1ps
module random_dfs_maze_carver_unit
  import rdmc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  rdmc_item_if.sink          item_i,
  rdmc_result_if.source      result_o
);

  localparam logic [EPOCH_W-1:0] EPOCH_LAST = {EPOCH_W{1'b1}};
  localparam logic [CNT_W-1:0]   CNT_CELLS  = CNT_W'(CELLS);

  // Configuration registers
  logic [SIZE_W-1:0] grid_width_q, grid_height_q;
  logic [X_W-1:0]    start_x_q;
  logic [Y_W-1:0]    start_y_q;
  logic              cfg_we;

  // Walk state
  logic [CNT_W-1:0]   count_q, count_d;
  logic [3:0]         tried_q, tried_d;
  logic               finished_q, finished_d;
  logic [X_W-1:0]     top_x_q, top_x_d;
  logic [Y_W-1:0]     top_y_q, top_y_d;
  logic [EPOCH_W-1:0] epoch_q, epoch_d;
  logic               clear_q, clear_d;
  logic [CELL_W-1:0]  sweep_q, sweep_d;

  // Decide stage
  logic              s_q, s_d;
  logic              b_op_q, b_halt_q, b_edge_q;
  logic [1:0]        b_dir_q;
  logic [X_W-1:0]    b_nx_q, b_sx_q;
  logic [Y_W-1:0]    b_ny_q, b_sy_q;

  // Result register
  logic              out_valid_q, out_valid_d;
  event_e            ev_q, ev_d;
  logic [X_W-1:0]    ox_q, ox_d;
  logic [Y_W-1:0]    oy_q, oy_d;
  logic [1:0]        odir_q, odir_d;
  logic              odone_q, odone_d;

  // Memory ports
  logic               vis_we, vis_re;
  logic [CELL_W-1:0]  vis_waddr, vis_raddr;
  logic [EPOCH_W-1:0] vis_wdata, vis_rdata;
  logic               stk_we;
  logic [CELL_W-1:0]  stk_waddr, stk_raddr;
  logic [CELL_W-1:0]  stk_wdata, stk_rdata;

  logic              accept, out_free, fire;
  logic [SIZE_W-1:0] w_eff, h_eff;
  logic [X_W-1:0]    sx, nx;
  logic [Y_W-1:0]    sy, ny;
  logic              edge_hit;
  logic [CNT_W-1:0]  cnt_m2;
  logic [3:0]        tried_new;
  logic              visited;

  // ---------------------------------------------------------------- APB
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= SIZE_W'(16);
      grid_height_q <= SIZE_W'(16);
      start_x_q     <= '0;
      start_y_q     <= '0;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_GRID_WIDTH:  grid_width_q  <= pwdata[SIZE_W-1:0];
        REG_GRID_HEIGHT: grid_height_q <= pwdata[SIZE_W-1:0];
        REG_START_X:     start_x_q     <= pwdata[X_W-1:0];
        REG_START_Y:     start_y_q     <= pwdata[Y_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_GRID_WIDTH:  prdata = DATA_W'(grid_width_q);
      REG_GRID_HEIGHT: prdata = DATA_W'(grid_height_q);
      REG_START_X:     prdata = DATA_W'(start_x_q);
      REG_START_Y:     prdata = DATA_W'(start_y_q);
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- read stage
  assign item_i.ready = !s_q && !clear_q;
  assign accept       = item_i.valid && item_i.ready;

  always_comb begin
    if (grid_width_q == '0) begin
      w_eff = SIZE_W'(1);
    end else if (grid_width_q > SIZE_W'(MAX_WIDTH)) begin
      w_eff = SIZE_W'(MAX_WIDTH);
    end else begin
      w_eff = grid_width_q;
    end
    if (grid_height_q == '0) begin
      h_eff = SIZE_W'(1);
    end else if (grid_height_q > SIZE_W'(MAX_HEIGHT)) begin
      h_eff = SIZE_W'(MAX_HEIGHT);
    end else begin
      h_eff = grid_height_q;
    end
    sx = ({1'b0, start_x_q} < w_eff) ? start_x_q : X_W'(w_eff - SIZE_W'(1));
    sy = ({1'b0, start_y_q} < h_eff) ? start_y_q : Y_W'(h_eff - SIZE_W'(1));
  end

  always_comb begin
    nx       = top_x_q;
    ny       = top_y_q;
    edge_hit = 1'b0;
    unique case (dir_e'(item_i.random_dir))
      DIR_NORTH: begin
        if ({1'b0, top_y_q} + SIZE_W'(1) >= h_eff) edge_hit = 1'b1;
        else ny = top_y_q + Y_W'(1);
      end
      DIR_EAST: begin
        if ({1'b0, top_x_q} + SIZE_W'(1) >= w_eff) edge_hit = 1'b1;
        else nx = top_x_q + X_W'(1);
      end
      DIR_SOUTH: begin
        if (top_y_q == '0) edge_hit = 1'b1;
        else ny = top_y_q - Y_W'(1);
      end
      DIR_WEST: begin
        if (top_x_q == '0) edge_hit = 1'b1;
        else nx = top_x_q - X_W'(1);
      end
      default: ;
    endcase
  end

  // Fetch the entry below the top in case this draw pops
  assign cnt_m2    = count_q - CNT_W'(2);
  assign vis_re    = accept;
  assign vis_raddr = {ny, nx};
  assign stk_raddr = cnt_m2[CELL_W-1:0];

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_op_q   <= item_i.op;
      b_dir_q  <= item_i.random_dir;
      b_halt_q <= finished_q || (count_q == '0);
      b_edge_q <= edge_hit;
      b_nx_q   <= nx;
      b_ny_q   <= ny;
      b_sx_q   <= sx;
      b_sy_q   <= sy;
    end
  end

  // ---------------------------------------------------------------- decide stage
  assign out_free  = !out_valid_q || result_o.ready;
  assign fire      = s_q && out_free;
  assign visited   = (vis_rdata == epoch_q);
  assign tried_new = tried_q | (4'b0001 << b_dir_q);

  always_comb begin
    s_d         = s_q;
    count_d     = count_q;
    tried_d     = tried_q;
    finished_d  = finished_q;
    top_x_d     = top_x_q;
    top_y_d     = top_y_q;
    epoch_d     = epoch_q;
    clear_d     = clear_q;
    sweep_d     = sweep_q;
    out_valid_d = out_valid_q && !result_o.ready;
    ev_d        = ev_q;
    ox_d        = ox_q;
    oy_d        = oy_q;
    odir_d      = odir_q;
    odone_d     = odone_q;
    vis_we      = 1'b0;
    vis_waddr   = {b_ny_q, b_nx_q};
    vis_wdata   = epoch_q;
    stk_we      = 1'b0;
    stk_waddr   = count_q[CELL_W-1:0];
    stk_wdata   = {b_ny_q, b_nx_q};

    if (accept) begin
      s_d = 1'b1;
    end

    if (clear_q) begin
      // Sweep: stale epochs go to zero, the start cell takes the live epoch
      vis_we    = 1'b1;
      vis_waddr = sweep_q;
      vis_wdata = (sweep_q == {top_y_q, top_x_q}) ? epoch_q : '0;
      sweep_d   = sweep_q + CELL_W'(1);
      if (sweep_q == {CELL_W{1'b1}}) begin
        clear_d = 1'b0;
      end
    end

    if (fire) begin
      s_d         = 1'b0;
      out_valid_d = 1'b1;
      ox_d        = top_x_q;
      oy_d        = top_y_q;
      odir_d      = b_dir_q;
      odone_d     = 1'b0;
      if (b_op_q == OP_START) begin
        ev_d       = EV_STARTED;
        ox_d       = b_sx_q;
        oy_d       = b_sy_q;
        odir_d     = '0;
        count_d    = CNT_W'(1);
        tried_d    = '0;
        finished_d = 1'b0;
        top_x_d    = b_sx_q;
        top_y_d    = b_sy_q;
        stk_we     = 1'b1;
        stk_waddr  = '0;
        stk_wdata  = {b_sy_q, b_sx_q};
        if (epoch_q == EPOCH_LAST) begin
          epoch_d = EPOCH_W'(1);
          clear_d = 1'b1;
          sweep_d = '0;
        end else begin
          epoch_d   = epoch_q + EPOCH_W'(1);
          vis_we    = 1'b1;
          vis_waddr = {b_sy_q, b_sx_q};
          vis_wdata = epoch_q + EPOCH_W'(1);
        end
      end else if (b_halt_q) begin
        ev_d       = EV_FINISHED;
        ox_d       = '0;
        oy_d       = '0;
        odir_d     = '0;
        odone_d    = 1'b1;
        finished_d = 1'b1;
      end else if (!b_edge_q && !visited) begin
        ev_d    = EV_CARVED;
        vis_we  = 1'b1;
        tried_d = '0;
        top_x_d = b_nx_q;
        top_y_d = b_ny_q;
        if (count_q < CNT_CELLS) begin
          stk_we  = 1'b1;
          count_d = count_q + CNT_W'(1);
        end
      end else if (tried_new == 4'hF) begin
        // Every direction tried: drop the top cell
        ev_d    = EV_BACKTRACKED;
        odir_d  = '0;
        count_d = count_q - CNT_W'(1);
        tried_d = '0;
        top_x_d = stk_rdata[X_W-1:0];
        top_y_d = stk_rdata[CELL_W-1:X_W];
        if (count_q == CNT_W'(1)) begin
          finished_d = 1'b1;
          odone_d    = 1'b1;
        end
      end else begin
        ev_d    = EV_REJECTED;
        tried_d = tried_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q         <= 1'b0;
      count_q     <= '0;
      tried_q     <= '0;
      finished_q  <= 1'b1;
      top_x_q     <= '0;
      top_y_q     <= '0;
      epoch_q     <= '0;
      clear_q     <= 1'b1;
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      s_q         <= s_d;
      count_q     <= count_d;
      tried_q     <= tried_d;
      finished_q  <= finished_d;
      top_x_q     <= top_x_d;
      top_y_q     <= top_y_d;
      epoch_q     <= epoch_d;
      clear_q     <= clear_d;
      sweep_q     <= sweep_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_q    <= ev_d;
    ox_q    <= ox_d;
    oy_q    <= oy_d;
    odir_q  <= odir_d;
    odone_q <= odone_d;
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.event_res = ev_q;
  assign result_o.cell_x    = ox_q;
  assign result_o.cell_y    = oy_q;
  assign result_o.carve_dir = odir_q;
  assign result_o.done_res  = odone_q;

  // ---------------------------------------------------------------- memories
  rdmc_ram #(
    .WIDTH (EPOCH_W),
    .DEPTH (CELLS)
  ) u_visited (
    .clk_i   (clk_i),
    .we_i    (vis_we),
    .waddr_i (vis_waddr),
    .wdata_i (vis_wdata),
    .re_i    (vis_re),
    .raddr_i (vis_raddr),
    .rdata_o (vis_rdata)
  );

  rdmc_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (accept),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

`ifndef SYNTH
  a_accept_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.valid && item_i.ready) |=> s_q)
    else $error("accepted item did not reach the decide stage");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_CELLS)
    else $error("stack count beyond capacity");

  a_tried_never_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tried_q != 4'hF)
    else $error("tried set left complete without a pop");

  a_finished_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.event_res == EV_FINISHED) |-> result_o.done_res)
    else $error("finished result without done flag");

  a_no_fire_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (clear_q && !$past(fire)) |-> !s_q)
    else $error("item in decide stage during visited sweep");
`endif

endmodule
